@@ rtl/core/lrpf_pkg.sv @@
// shared types and constants of the landmark radius point filter
`default_nettype none

package lrpf_pkg;

	// landmark table size and derived widths
	localparam int MAX_LANDMARKS = 16;
	localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// field widths
	localparam int COORD_W = 24;
	localparam int BOX_W = COORD_W + 1;
	localparam int ID_W = 16;
	localparam int RAD_W = 16;
	localparam int R2_W = 2 * RAD_W;
	localparam int SQ_W = 2 * COORD_W;

	// empty bounding box limits
	localparam logic signed [BOX_W-1:0] BOX_POS_MAX = {1'b0, {(BOX_W-1){1'b1}}};
	localparam logic signed [BOX_W-1:0] BOX_NEG_MIN = {1'b1, {(BOX_W-1){1'b0}}};

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEIGHT_MIN = 2'd0,
		CFG_HEIGHT_MAX = 2'd1,
		CFG_RADIUS     = 2'd2
	} cfg_reg_t;

	// register reset values
	localparam logic signed [COORD_W-1:0] HEIGHT_MIN_RST = -24'sd500;
	localparam logic signed [COORD_W-1:0] HEIGHT_MAX_RST = 24'sd500;
	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd350;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_POINT = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_KEPT     = 4'd0,
		ST_HEIGHT   = 4'd1,
		ST_BOX      = 4'd2,
		ST_RADIUS   = 4'd3,
		ST_EMPTY    = 4'd4,
		ST_ADDED    = 4'd5,
		ST_DUP      = 4'd6,
		ST_INVALID  = 4'd7,
		ST_FULL     = 4'd8,
		ST_CLEARED  = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		logic [1:0]                 action;
		logic [ID_W-1:0]            tag_id;
		logic                       position_valid;
		logic signed [COORD_W-1:0]  x_mm;
		logic signed [COORD_W-1:0]  y_mm;
		logic signed [COORD_W-1:0]  z_mm;
	} in_item_t;

	typedef struct packed {
		status_t                    status;
		logic signed [COORD_W-1:0]  out_x;
		logic signed [COORD_W-1:0]  out_y;
		logic signed [COORD_W-1:0]  out_z;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		action_t                    act;
		logic [ID_W-1:0]            tag_id;
		logic                       pos_ok;
		logic                       height_ok;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
	} cmd_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/landmark_radius_point_filter_core.sv @@
// top level of the landmark radius point filter: config registers, front, queue, back
//
// channel   direction  handshake            payload
// in        receive    in_valid / in_stall  in_data (action, id, valid flag, x, y, z)
// out       send       out_valid/out_stall  out_data (status, x, y, z)
// cfg       receive    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// with the queue empty and the output free, an item that scans the table (an add to a
// non-empty table, or a point inside the window and box) goes through the front hold
// register, the queue, the back command register, the scan stages and the finish step
// before out_valid rises; others skip the scan, which reads one landmark per cycle
// arst_n clears the landmark count, the box, the queue and all valid flags
// the front keeps taking items while the back is busy, until the command queue fills
// a stalled result holds in the output register; the back waits before loading the next
`default_nettype none

module landmark_radius_point_filter_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  lrpf_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  wire                           out_stall,
	output lrpf_pkg::out_item_t           out_data,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [lrpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [23:0]                    cfg_data
);
	import lrpf_pkg::*;

	// configuration registers
	logic signed [COORD_W-1:0]  hmin_q;
	logic signed [COORD_W-1:0]  hmax_q;
	logic [RAD_W-1:0]           rad_q;

	// front to queue to back
	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	cmd_t       head;
	q_stat_t    q_stat;

	// writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmin_q <= HEIGHT_MIN_RST;
			hmax_q <= HEIGHT_MAX_RST;
			rad_q  <= RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEIGHT_MIN: hmin_q <= $signed(cfg_data);
				CFG_HEIGHT_MAX: hmax_q <= $signed(cfg_data);
				CFG_RADIUS:     rad_q  <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// front classifies: drops unused codes, checks the height window
	lrpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.height_min (hmin_q),
		.height_max (hmax_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	lrpf_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// back owns the table and box, scans landmarks and drives the result register
	lrpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.keep_radius (rad_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

@@ rtl/core/lrpf_front.sv @@
// front part: accepts input items, classifies them and hands commands to the queue
`default_nettype none

module lrpf_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  lrpf_pkg::in_item_t          in_data,
	input  wire signed [23:0]           height_min,
	input  wire signed [23:0]           height_max,
	input  lrpf_pkg::q_stat_t           q_stat,
	output logic                        push,
	output lrpf_pkg::cmd_t              push_cmd
);
	import lrpf_pkg::*;

	logic   hold_vld_q;
	cmd_t   hold_q;
	cmd_t   cmd_d;
	logic   accept;
	logic   known;

	assign in_stall = hold_vld_q && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = hold_vld_q && !q_stat.full;
	assign push_cmd = hold_q;

	// unused action code is taken and dropped
	assign known = (in_data.action == ACT_CLEAR) || (in_data.action == ACT_ADD) ||
		(in_data.action == ACT_POINT);

	always_comb begin
		cmd_d.act       = action_t'(in_data.action);
		cmd_d.tag_id    = in_data.tag_id;
		cmd_d.pos_ok    = in_data.position_valid;
		cmd_d.height_ok = (in_data.z_mm >= height_min) && (in_data.z_mm <= height_max);
		cmd_d.x         = in_data.x_mm;
		cmd_d.y         = in_data.y_mm;
		cmd_d.z         = in_data.z_mm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
		end else if (accept) begin
			hold_vld_q <= known;
		end else if (push) begin
			hold_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= cmd_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lrpf_cmd_fifo.sv @@
// short command queue between front and back
`default_nettype none

module lrpf_cmd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lrpf_pkg::cmd_t      push_cmd,
	input  wire                 pop,
	output lrpf_pkg::cmd_t      head,
	output lrpf_pkg::q_stat_t   q_stat
);
	import lrpf_pkg::*;

	cmd_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  level_q;

	assign q_stat.full  = (level_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (level_q == '0);
	assign head         = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push || pop)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("command queue underflow");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= QCNT_W'(QDEPTH))
		else $error("command queue level above depth");

endmodule

`default_nettype wire

@@ rtl/core/lrpf_back.sv @@
// back part: landmark table, bounding box, scan pipeline and result register
`default_nettype none

module lrpf_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lrpf_pkg::cmd_t          head,
	input  lrpf_pkg::q_stat_t       q_stat,
	output logic                    pop,
	input  wire [15:0]              keep_radius,
	output logic                    out_valid,
	input  wire                     out_stall,
	output lrpf_pkg::out_item_t     out_data
);
	import lrpf_pkg::*;

	// landmark storage
	logic signed [COORD_W-1:0]  lm_x [MAX_LANDMARKS];
	logic signed [COORD_W-1:0]  lm_y [MAX_LANDMARKS];
	logic [ID_W-1:0]            lm_id [MAX_LANDMARKS];

	back_state_t                state_q, state_d;
	cmd_t                       cmd_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [BOX_W-1:0]    bxl_q, bxh_q, byl_q, byh_q;
	logic [R2_W-1:0]            r2_q;
	logic                       early_q;
	status_t                    early_st_q;
	logic                       hit_q;
	logic                       iss_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       ovld_q;
	out_item_t                  out_q;

	// scan pipeline
	logic                       v_s1, v_s2, v_s3;
	logic signed [COORD_W-1:0]  lx_s1, ly_s1;
	logic [ID_W-1:0]            lid_s1;
	logic signed [BOX_W-1:0]    dx_s2, dy_s2;
	logic                       m_s2, m_s3;
	logic [SQ_W-1:0]            sqx_s3, sqy_s3;

	// next state controls
	logic                       go_scan, set_early, ld_out;
	status_t                    early_st_d, fin_st;
	logic                       do_store, do_clear;

	logic signed [BOX_W-1:0]    hx, hy, qx, qy, rad_s;
	logic                       outside, last_idx, drained, out_free, dist_ok;
	logic signed [2*BOX_W-1:0]  pxx, pyy;
	logic [SQ_W:0]              dsum;
	logic [R2_W-1:0]            r2_d;

	assign out_free = !ovld_q || !out_stall;
	assign hx       = $signed({head.x[COORD_W-1], head.x});
	assign hy       = $signed({head.y[COORD_W-1], head.y});
	assign qx       = $signed({cmd_q.x[COORD_W-1], cmd_q.x});
	assign qy       = $signed({cmd_q.y[COORD_W-1], cmd_q.y});
	assign rad_s    = $signed({{(BOX_W-RAD_W){1'b0}}, keep_radius});
	assign outside  = (hx < bxl_q) || (hx > bxh_q) || (hy < byl_q) || (hy > byh_q);
	assign last_idx = (CNT_W'(idx_q) == cnt_q - 1'b1);
	assign drained  = !iss_q && !v_s1 && !v_s2 && !v_s3;
	assign r2_d     = R2_W'(keep_radius) * R2_W'(keep_radius);

	assign pxx     = dx_s2 * dx_s2;
	assign pyy     = dy_s2 * dy_s2;
	assign dsum    = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign dist_ok = (dsum <= (SQ_W + 1)'(r2_q));

	always_comb begin
		case (cmd_q.act)
			ACT_CLEAR: fin_st = ST_CLEARED;
			ACT_ADD: begin
				if (hit_q) begin
					fin_st = ST_DUP;
				end else if (!cmd_q.pos_ok) begin
					fin_st = ST_INVALID;
				end else if (cnt_q >= CNT_W'(MAX_LANDMARKS)) begin
					fin_st = ST_FULL;
				end else begin
					fin_st = ST_ADDED;
				end
			end
			ACT_POINT: begin
				if (early_q) begin
					fin_st = early_st_q;
				end else if (hit_q) begin
					fin_st = ST_KEPT;
				end else begin
					fin_st = ST_RADIUS;
				end
			end
			default: fin_st = ST_CLEARED;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		go_scan    = 1'b0;
		set_early  = 1'b0;
		early_st_d = ST_EMPTY;
		ld_out     = 1'b0;
		do_store   = 1'b0;
		do_clear   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					case (head.act)
						ACT_CLEAR: state_d = BK_FIN;
						ACT_ADD: begin
							if (cnt_q != '0) begin
								go_scan = 1'b1;
								state_d = BK_SCAN;
							end else begin
								state_d = BK_FIN;
							end
						end
						ACT_POINT: begin
							if (cnt_q == '0) begin
								set_early  = 1'b1;
								early_st_d = ST_EMPTY;
								state_d    = BK_FIN;
							end else if (!head.height_ok) begin
								set_early  = 1'b1;
								early_st_d = ST_HEIGHT;
								state_d    = BK_FIN;
							end else if (outside) begin
								set_early  = 1'b1;
								early_st_d = ST_BOX;
								state_d    = BK_FIN;
							end else begin
								go_scan = 1'b1;
								state_d = BK_SCAN;
							end
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_SCAN: begin
				if (drained) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					ld_out   = 1'b1;
					do_store = (cmd_q.act == ACT_ADD) && (fin_st == ST_ADDED);
					do_clear = (cmd_q.act == ACT_CLEAR);
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table count, box and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bxl_q  <= BOX_POS_MAX;
			bxh_q  <= BOX_NEG_MIN;
			byl_q  <= BOX_POS_MAX;
			byh_q  <= BOX_NEG_MIN;
			iss_q  <= 1'b0;
			idx_q  <= '0;
			hit_q  <= 1'b0;
			early_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == BK_SCAN) && iss_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (pop) begin
				early_q <= set_early;
				hit_q   <= 1'b0;
				iss_q   <= go_scan;
				idx_q   <= '0;
			end else if (state_q == BK_SCAN) begin
				if (iss_q) begin
					if (last_idx) begin
						iss_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				if (v_s3 && ((cmd_q.act == ACT_ADD) ? m_s3 : dist_ok)) begin
					hit_q <= 1'b1;
				end
			end
			if (do_clear) begin
				cnt_q <= '0;
				bxl_q <= BOX_POS_MAX;
				bxh_q <= BOX_NEG_MIN;
				byl_q <= BOX_POS_MAX;
				byh_q <= BOX_NEG_MIN;
			end else if (do_store) begin
				cnt_q <= cnt_q + 1'b1;
				if (qx - rad_s < bxl_q) begin
					bxl_q <= qx - rad_s;
				end
				if (qx + rad_s > bxh_q) begin
					bxh_q <= qx + rad_s;
				end
				if (qy - rad_s < byl_q) begin
					byl_q <= qy - rad_s;
				end
				if (qy + rad_s > byh_q) begin
					byh_q <= qy + rad_s;
				end
			end
			if (ld_out) begin
				ovld_q <= 1'b1;
			end else if (!out_stall) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// payload and pipeline data
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q      <= head;
			early_st_q <= early_st_d;
			r2_q       <= r2_d;
		end
		lx_s1  <= lm_x[idx_q];
		ly_s1  <= lm_y[idx_q];
		lid_s1 <= lm_id[idx_q];
		dx_s2  <= qx - $signed({lx_s1[COORD_W-1], lx_s1});
		dy_s2  <= qy - $signed({ly_s1[COORD_W-1], ly_s1});
		m_s2   <= (lid_s1 == cmd_q.tag_id);
		sqx_s3 <= pxx[SQ_W-1:0];
		sqy_s3 <= pyy[SQ_W-1:0];
		m_s3   <= m_s2;
		if (do_store) begin
			lm_x[cnt_q[IDX_W-1:0]]  <= cmd_q.x;
			lm_y[cnt_q[IDX_W-1:0]]  <= cmd_q.y;
			lm_id[cnt_q[IDX_W-1:0]] <= cmd_q.tag_id;
		end
		if (ld_out) begin
			out_q.status <= fin_st;
			out_q.out_x  <= (fin_st == ST_KEPT) ? cmd_q.x : '0;
			out_q.out_y  <= (fin_st == ST_KEPT) ? cmd_q.y : '0;
			out_q.out_z  <= (fin_st == ST_KEPT) ? cmd_q.z : '0;
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LANDMARKS))
		else $error("landmark count above table size");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> cnt_q != '0)
		else $error("scan started on an empty table");

	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovld_q) |-> $past(state_q) == BK_FIN)
		else $error("result loaded outside the finish step");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $past(v_s2, 1))
		else $error("scan pipeline valid out of order");

endmodule

`default_nettype wire
